// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the auto exposure checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AEGL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AEGL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/aegl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aegl_pkg
// Types, constants and the gain ladder for the auto exposure gain loop.
// ----------------------------------------------------------------------------
package aegl_pkg;

  localparam int ExpW      = 16;
  localparam int LumaW     = 8;
  localparam int GainSteps = 6;
  localparam int GainIdxW  = 3;
  localparam int CodeW     = 5;
  localparam int SettleW   = 8;
  localparam int DampRegW  = 9;
  localparam int DampW     = 11;
  localparam int AluW      = 28;
  localparam int DivSteps  = 16;
  localparam int DivCntW   = $clog2(DivSteps);
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;

  localparam int RatioOne     = 256;
  localparam int RatioLumaZero = 512;
  localparam int DampMin      = 64;
  localparam int DampMax      = 1024;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_MAG,
    ST_MULD,
    ST_FIX,
    ST_MULE,
    ST_SCALE,
    ST_DONE
  } state_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_AUTO_ENABLE  = 3'd0,
    REG_TARGET_LUMA  = 3'd1,
    REG_DEADBAND     = 3'd2,
    REG_SETTLE_LIMIT = 3'd3,
    REG_DAMPING      = 3'd4,
    REG_MAX_EXPOSURE = 3'd5
  } cfg_reg_t;

  function automatic logic [CodeW-1:0] ladder_code(input logic [GainIdxW-1:0] idx);
    logic [GainIdxW-1:0] step;
    logic [CodeW-1:0]    code;
    step = (idx > GainIdxW'(GainSteps - 1)) ? GainIdxW'(GainSteps - 1) : idx;
    case (step)
      3'd0:    code = 5'h00;
      3'd1:    code = 5'h01;
      3'd2:    code = 5'h03;
      3'd3:    code = 5'h07;
      3'd4:    code = 5'h0F;
      default: code = 5'h1F;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/aegl_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aegl_if
// Request channels of the auto exposure gain loop: statistics, results, config.
// ----------------------------------------------------------------------------
interface aegl_stats_if import aegl_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            stats_valid;
  logic [LumaW-1:0] luma;
  logic [ExpW-1:0] current_exposure;

  modport source (output valid, stats_valid, luma, current_exposure, input ready);
  modport sink   (input valid, stats_valid, luma, current_exposure, output ready);
endinterface

interface aegl_result_if import aegl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ExpW-1:0]     next_exposure;
  logic                exposure_write;
  logic [CodeW-1:0]    gain_code;
  logic                gain_write;
  logic [GainIdxW-1:0] gain_level;
  logic [SettleW-1:0]  settle_level;
  logic                in_deadband;

  modport source (output valid, next_exposure, exposure_write, gain_code, gain_write,
                  gain_level, settle_level, in_deadband, input ready);
  modport sink   (input valid, next_exposure, exposure_write, gain_code, gain_write,
                  gain_level, settle_level, in_deadband, output ready);
endinterface

interface aegl_cfg_if import aegl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/auto_exposure_gain_loop_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// auto_exposure_gain_loop_unit
// Proportional auto exposure with an analog gain ladder, built on one shared
// add/subtract unit under a sequencer.
// ----------------------------------------------------------------------------
//  channel   dir   payload
//  cfg       in    index, data (register write)
//  stats     in    stats_valid, luma, current_exposure
//  result    out   next_exposure, exposure_write, gain_code, gain_write,
//                  gain_level, settle_level, in_deadband
//
//  A skipped or in-deadband request goes from ST_CHECK straight to ST_DONE.
//  A correcting request runs 16 restoring divide steps (skipped when luma
//  is zero), then up to 9 and 11 shift-add multiply steps, all on the one adder.
//  rst is synchronous; stats.ready is low from accept until the result is
//  loaded into the output register, which holds while result.ready is low.
// ----------------------------------------------------------------------------
module auto_exposure_gain_loop_unit import aegl_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  aegl_cfg_if.sink      cfg,
  aegl_stats_if.sink    stats,
  aegl_result_if.source result
);

  state_t state, state_next;

  logic                auto_enable;
  logic [LumaW-1:0]    target_luma;
  logic [LumaW-1:0]    deadband;
  logic [SettleW-1:0]  settle_limit;
  logic [DampRegW-1:0] damping;
  logic [ExpW-1:0]     max_exposure;

  logic [GainIdxW-1:0] gain_index;
  logic [SettleW-1:0]  settle_counter;

  logic                stat_ok;
  logic [LumaW-1:0]    luma;
  logic [ExpW-1:0]     cur;
  logic                neg_err;
  logic                ratio_pos;
  logic [ExpW-1:0]     quo;
  logic [LumaW-1:0]    rem;
  logic [DivCntW-1:0]  cnt;
  logic [AluW-1:0]     mcand;
  logic [DampW-1:0]    mplier;
  logic [AluW-1:0]     acc;

  logic [ExpW-1:0]     res_exposure;
  logic                res_exp_wr;
  logic                res_gain_wr;
  logic [GainIdxW-1:0] res_gain;
  logic [SettleW-1:0]  res_settle;
  logic                res_inband;

  logic                out_valid;
  logic                out_load;

  logic [AluW-1:0]     alu_a;
  logic [AluW-1:0]     alu_b;
  logic                alu_sub;
  logic [AluW-1:0]     alu_res;

  logic                err_neg;
  logic [LumaW-1:0]    aerr;
  logic                active;
  logic                div_borrow;
  logic [LumaW:0]      trial;
  logic [DampRegW-1:0] dmp;
  logic [DampW-1:0]    damp_v;
  logic [AluW-9:0]     scaled;
  logic [ExpW-1:0]     maxe;

  assign cfg.ready   = 1'b1;
  assign stats.ready = (state == ST_IDLE);
  assign out_load    = (state == ST_DONE) && (!out_valid || result.ready);

  // shared adder
  assign trial = {rem, quo[ExpW-1]};

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      ST_CHECK: begin
        alu_a   = AluW'(target_luma);
        alu_b   = AluW'(luma);
        alu_sub = 1'b1;
      end
      ST_DIV: begin
        alu_a   = AluW'(trial);
        alu_b   = AluW'(luma);
        alu_sub = 1'b1;
      end
      ST_MAG: begin
        if (quo >= ExpW'(RatioOne)) begin
          alu_a = AluW'(quo);
          alu_b = AluW'(RatioOne);
        end else begin
          alu_a = AluW'(RatioOne);
          alu_b = AluW'(quo);
        end
        alu_sub = 1'b1;
      end
      ST_MULD, ST_MULE: begin
        alu_a = acc;
        alu_b = mcand;
      end
      ST_FIX: begin
        alu_a = AluW'(RatioOne);
        if (ratio_pos) begin
          alu_b = AluW'(acc[AluW-1:8]);
        end else begin
          alu_b   = AluW'(acc[AluW-1:8]) + AluW'(|acc[7:0]);
          alu_sub = 1'b1;
        end
      end
      default: ;
    endcase
    alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  end

  assign err_neg    = alu_res[AluW-1];
  assign aerr       = err_neg ? (~alu_res[LumaW-1:0] + LumaW'(1)) : alu_res[LumaW-1:0];
  assign active     = auto_enable && stat_ok;
  assign div_borrow = alu_res[AluW-1];
  assign dmp        = (damping > DampRegW'(RatioOne)) ? DampRegW'(RatioOne) : damping;
  assign scaled     = (acc[AluW-1:8] == '0) ? (AluW-8)'(1) : acc[AluW-1:8];
  assign maxe       = (max_exposure == '0) ? ExpW'(1) : max_exposure;

  always_comb begin
    if ($signed(alu_res) < $signed(AluW'(DampMin))) begin
      damp_v = DampW'(DampMin);
    end else if ($signed(alu_res) > $signed(AluW'(DampMax))) begin
      damp_v = DampW'(DampMax);
    end else begin
      damp_v = alu_res[DampW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (stats.valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (!active || aerr <= deadband) state_next = ST_DONE;
        else if (luma == '0) state_next = ST_MAG;
        else state_next = ST_DIV;
      end
      ST_DIV: begin
        if (cnt == DivCntW'(DivSteps - 1)) state_next = ST_MAG;
      end
      ST_MAG:   state_next = ST_MULD;
      ST_MULD: begin
        if (mplier[DampW-1:1] == '0) state_next = ST_FIX;
      end
      ST_FIX:   state_next = ST_MULE;
      ST_MULE: begin
        if (mplier[DampW-1:1] == '0) state_next = ST_SCALE;
      end
      ST_SCALE: state_next = ST_DONE;
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        stat_ok <= stats.stats_valid;
        luma    <= stats.luma;
        cur     <= (stats.current_exposure == '0) ? ExpW'(1) : stats.current_exposure;
      end
      ST_CHECK: begin
        neg_err      <= err_neg;
        res_exposure <= '0;
        res_exp_wr   <= 1'b0;
        res_gain_wr  <= 1'b0;
        res_gain     <= gain_index;
        res_settle   <= settle_counter;
        res_inband   <= 1'b0;
        rem          <= '0;
        cnt          <= '0;
        quo          <= (luma == '0) ? ExpW'(RatioLumaZero) : {target_luma, 8'h00};
        if (active) begin
          if (aerr <= deadband) begin
            res_inband <= 1'b1;
            if (settle_counter < settle_limit) res_settle <= settle_counter + SettleW'(1);
          end else begin
            res_settle <= '0;
          end
        end
      end
      ST_DIV: begin
        rem <= div_borrow ? trial[LumaW-1:0] : alu_res[LumaW-1:0];
        quo <= {quo[ExpW-2:0], !div_borrow};
        cnt <= cnt + DivCntW'(1);
      end
      ST_MAG: begin
        ratio_pos <= (quo >= ExpW'(RatioOne));
        mcand     <= alu_res;
        mplier    <= DampW'(dmp);
        acc       <= '0;
      end
      ST_MULD, ST_MULE: begin
        if (mplier[0]) acc <= alu_res;
        mcand  <= {mcand[AluW-2:0], 1'b0};
        mplier <= {1'b0, mplier[DampW-1:1]};
      end
      ST_FIX: begin
        mcand  <= AluW'(cur);
        mplier <= damp_v;
        acc    <= '0;
      end
      ST_SCALE: begin
        res_exp_wr <= 1'b1;
        if (scaled > (AluW-8)'(maxe)) begin
          res_exposure <= maxe;
          if (gain_index < GainIdxW'(GainSteps - 1)) begin
            res_gain    <= gain_index + GainIdxW'(1);
            res_gain_wr <= 1'b1;
          end
        end else if (neg_err && gain_index != '0 && scaled < (AluW-8)'(maxe >> 1)) begin
          res_gain     <= gain_index - GainIdxW'(1);
          res_gain_wr  <= 1'b1;
          res_exp_wr   <= 1'b0;
          res_exposure <= '0;
        end else begin
          res_exposure <= scaled[ExpW-1:0];
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // state commit and config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_index     <= '0;
      settle_counter <= '0;
      auto_enable    <= 1'b1;
      target_luma    <= 8'd128;
      deadband       <= 8'd8;
      settle_limit   <= 8'd4;
      damping        <= 9'd128;
      max_exposure   <= 16'hFFFF;
    end else begin
      if (out_load) begin
        gain_index     <= res_gain;
        settle_counter <= res_settle;
      end
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_AUTO_ENABLE: begin
            auto_enable    <= cfg.data[0];
            settle_counter <= '0;
          end
          REG_TARGET_LUMA:  target_luma  <= cfg.data[LumaW-1:0];
          REG_DEADBAND:     deadband     <= cfg.data[LumaW-1:0];
          REG_SETTLE_LIMIT: settle_limit <= cfg.data[SettleW-1:0];
          REG_DAMPING:      damping      <= cfg.data[DampRegW-1:0];
          REG_MAX_EXPOSURE: max_exposure <= cfg.data[ExpW-1:0];
          default: ;
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.next_exposure  <= res_exposure;
      result.exposure_write <= res_exp_wr;
      result.gain_code      <= ladder_code(res_gain);
      result.gain_write     <= res_gain_wr;
      result.gain_level     <= res_gain;
      result.settle_level   <= res_settle;
      result.in_deadband    <= res_inband;
    end
  end

  assign result.valid = out_valid;

endmodule

// ----- rtl/aegl_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aegl_checker
// Port-level checks on the auto exposure gain loop, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aegl_checker import aegl_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                stats_valid,
  input logic                stats_ready,
  input logic                result_valid,
  input logic                result_ready,
  input logic [ExpW-1:0]     next_exposure,
  input logic                exposure_write,
  input logic                gain_write,
  input logic [GainIdxW-1:0] gain_level,
  input logic                in_deadband
);

  `AEGL_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid, "stalled result dropped")
  `AEGL_ASSERT_NEXT(a_one_at_a_time, clk, rst, stats_valid && stats_ready, !stats_ready, "request taken while busy")
  `AEGL_ASSERT_SAME(a_no_write_zero, clk, rst, result_valid && !exposure_write, next_exposure == '0, "exposure without write")
  `AEGL_ASSERT_SAME(a_deadband_quiet, clk, rst, result_valid && in_deadband, !exposure_write && !gain_write && gain_level < GainIdxW'(GainSteps), "write inside deadband")

endmodule

bind auto_exposure_gain_loop_unit aegl_checker u_aegl_checker (
  .clk            (clk),
  .rst            (rst),
  .stats_valid    (stats.valid),
  .stats_ready    (stats.ready),
  .result_valid   (result.valid),
  .result_ready   (result.ready),
  .next_exposure  (result.next_exposure),
  .exposure_write (result.exposure_write),
  .gain_write     (result.gain_write),
  .gain_level     (result.gain_level),
  .in_deadband    (result.in_deadband)
);
